// ===== sv/cst_pkg.sv =====
`default_nettype none
package cst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_W = 32;
  localparam int PID_W = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_WAIT  = 2'd2,
    KIND_POST  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NOT_FOUND      = 3'd1,
    ST_TABLE_FULL     = 3'd2,
    ST_TOO_MANY_LINKS = 3'd3,
    ST_QUEUE_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_READ,
    S_EXEC,
    S_WREAD,
    S_WDATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [KEY_W-1:0]   sem_key;
    logic [PID_W-1:0]   caller_pid;
    logic [COUNT_W-1:0] initial_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             caller_blocked;
    logic             wake_valid;
    logic [PID_W-1:0] wake_pid;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/cst_ram.sv =====
`default_nettype none
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/counting_semaphore_table.sv =====
// One request is in flight at a time. A post that releases a waiter reads the waiter memory
// after the slot update, so its result comes later than that of the other requests.
// The key scan reads the slot memory one entry per cycle; a result left waiting at the
// output holds the next one back and stalls the input. After reset the block clears every
// entry of the slot memory before taking a request; the waiter memory is not cleared.
`default_nettype none
module counting_semaphore_table #(
  parameter int SLOTS       = cst_pkg::SLOTS_DEF,
  parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output cst_pkg::out_item_t out_data
);
  import cst_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int WD = SLOTS * QUEUE_DEPTH;
  localparam int WW = (WD > 1) ? $clog2(WD) : 1;
  localparam int SLOTS_RAM = (SLOTS > 1) ? SLOTS : 2;
  localparam int WD_RAM = (WD > 1) ? WD : 2;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [FW-1:0] QD_F = FW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QD_LAST = QW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [FW-1:0]      links;
    logic [QW-1:0]      head;
    logic [FW-1:0]      fill;
  } slot_t;
  localparam int SLOT_W = $bits(slot_t);

  state_t    state_r, state_nxt;
  in_item_t  req_r, req_nxt;
  out_item_t res_r, res_nxt;
  out_item_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic      hit_ok_r, hit_ok_nxt, free_ok_r, free_ok_nxt;
  logic      clr_r, clr_nxt;
  logic [QW-1:0] wpos_r, wpos_nxt;

  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  slot_t         s_wdata, s_rdata;
  logic          w_we;
  logic [WW-1:0] w_waddr, w_raddr;
  logic [PID_W-1:0] w_rdata;

  cst_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS_RAM)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  cst_ram #(.WIDTH(PID_W), .DEPTH(WD_RAM)) u_wait_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(req_r.caller_pid),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  logic [SW-1:0] scan_addr;
  logic [SW-1:0] tgt;
  logic [QW:0]   pos_sum;
  logic [QW-1:0] pos_wrap;

  assign in_ready  = (state_r == S_IDLE) && !clr_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      clr_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    pend_r    <= pend_nxt;
    hit_r     <= hit_nxt;
    free_r    <= free_nxt;
    hit_ok_r  <= hit_ok_nxt;
    free_ok_r <= free_ok_nxt;
    wpos_r    <= wpos_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    hit_ok_nxt    = hit_ok_r;
    free_ok_nxt   = free_ok_r;
    clr_nxt       = clr_r;
    wpos_nxt      = wpos_r;
    s_we          = 1'b0;
    s_waddr       = idx_r;
    s_wdata       = '0;
    scan_addr     = '0;
    s_raddr       = scan_addr;
    w_we          = 1'b0;
    w_waddr       = '0;
    w_raddr       = '0;
    tgt           = hit_ok_r ? hit_r : free_r;
    pos_sum       = '0;
    pos_wrap      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (clr_r) begin
          // Post-reset sweep: one slot cleared per cycle.
          s_we    = 1'b1;
          s_waddr = idx_r;
          idx_nxt = (idx_r == LAST_SLOT) ? '0 : idx_r + SW'(1);
          if (idx_r == LAST_SLOT) begin
            clr_nxt = 1'b0;
          end
        end else if (in_valid) begin
          req_nxt     = in_data;
          hit_ok_nxt  = 1'b0;
          free_ok_nxt = 1'b0;
          idx_nxt     = '0;
          s_raddr     = '0;
          state_nxt   = (SLOTS > 1) ? S_SCAN : S_SCAN_LAST;
        end
      end
      S_SCAN, S_SCAN_LAST: begin
        // s_rdata holds slot idx_r; the next address is already presented.
        s_raddr = idx_r + SW'(1);
        if (!hit_ok_r && s_rdata.key == req_r.sem_key) begin
          hit_ok_nxt = 1'b1;
          hit_nxt    = idx_r;
        end
        if (!free_ok_r && s_rdata.key == '0) begin
          free_ok_nxt = 1'b1;
          free_nxt    = idx_r;
        end
        if (state_r == S_SCAN_LAST) begin
          state_nxt = S_READ;
        end else begin
          idx_nxt = idx_r + SW'(1);
          if (idx_r + SW'(1) == LAST_SLOT) begin
            state_nxt = S_SCAN_LAST;
          end
        end
      end
      S_READ: begin
        s_raddr   = tgt;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        s_raddr = tgt;
        s_waddr = tgt;
        s_wdata = s_rdata;
        pend_nxt = '0;
        pend_nxt.status = ST_OK;
        state_nxt = S_DONE;
        if (req_r.sem_key == '0) begin
          pend_nxt.status = ST_NOT_FOUND;
        end else if (req_r.kind == KIND_OPEN) begin
          if (!hit_ok_r && !free_ok_r) begin
            pend_nxt.status = ST_TABLE_FULL;
          end else begin
            if (!hit_ok_r) begin
              s_wdata       = '0;
              s_wdata.key   = req_r.sem_key;
              s_wdata.count = req_r.initial_count;
            end
            if (s_wdata.links >= QD_F) begin
              pend_nxt.status = ST_TOO_MANY_LINKS;
            end else begin
              s_wdata.links = s_wdata.links + FW'(1);
            end
            s_we = 1'b1;
          end
        end else if (!hit_ok_r) begin
          pend_nxt.status = ST_NOT_FOUND;
        end else if (req_r.kind == KIND_CLOSE) begin
          s_we = 1'b1;
          if (s_rdata.links <= FW'(1)) begin
            s_wdata = '0;
          end else begin
            s_wdata.links = s_rdata.links - FW'(1);
          end
        end else if (req_r.kind == KIND_WAIT) begin
          if (s_rdata.count != '0) begin
            s_we = 1'b1;
            s_wdata.count = s_rdata.count - COUNT_W'(1);
          end else if (s_rdata.fill >= QD_F) begin
            pend_nxt.status = ST_QUEUE_FULL;
          end else begin
            pos_sum = {1'b0, s_rdata.head} + (QW+1)'(s_rdata.fill);
            pos_wrap = (pos_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                       QW'(pos_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(pos_sum);
            w_we    = 1'b1;
            w_waddr = WW'(hit_r) * WW'(QUEUE_DEPTH) + WW'(pos_wrap);
            s_we    = 1'b1;
            s_wdata.fill = s_rdata.fill + FW'(1);
            pend_nxt.caller_blocked = 1'b1;
          end
        end else begin
          if (s_rdata.fill != '0) begin
            wpos_nxt  = s_rdata.head;
            s_we      = 1'b1;
            s_wdata.head = (s_rdata.head == QD_LAST) ? '0 : s_rdata.head + QW'(1);
            s_wdata.fill = s_rdata.fill - FW'(1);
            state_nxt = S_WREAD;
          end else if (s_rdata.count != COUNT_MAX) begin
            s_we = 1'b1;
            s_wdata.count = s_rdata.count + COUNT_W'(1);
          end
        end
      end
      S_WREAD: begin
        w_raddr   = WW'(hit_r) * WW'(QUEUE_DEPTH) + WW'(wpos_r);
        state_nxt = S_WDATA;
      end
      S_WDATA: begin
        w_raddr             = WW'(hit_r) * WW'(QUEUE_DEPTH) + WW'(wpos_r);
        pend_nxt.wake_valid = 1'b1;
        pend_nxt.wake_pid   = w_rdata;
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        // The finished result moves to the output only once the previous one is gone.
        if (!out_valid_r || out_ready) begin
          res_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE && !clr_r))
    else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |=> out_valid)
    else $error("result not presented");
  a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.caller_blocked) |-> out_data.status == ST_OK)
    else $error("blocked with error");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.caller_blocked && out_data.wake_valid))
    else $error("block and wake together");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_counting_semaphore_table.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_counting_semaphore_table;
  import cst_pkg::*;

  localparam int NSLOT = 16;
  localparam int QDEPTH = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  counting_semaphore_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the semaphore table.
  logic [31:0] tab_key [NSLOT];
  logic [15:0] tab_count [NSLOT];
  int          tab_links [NSLOT];
  int          tab_head [NSLOT];
  int          tab_fill [NSLOT];
  logic [15:0] tab_waiters [NSLOT][QDEPTH];

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        hold_cycles = 0;
  bit        long_hold = 1'b0;
  logic [31:0] key_pool [6];

  function automatic void clear_entry(int s);
    tab_key[s] = '0;
    tab_count[s] = '0;
    tab_links[s] = 0;
    tab_head[s] = 0;
    tab_fill[s] = 0;
  endfunction

  function automatic out_item_t semaphore_apply(in_item_t req);
    out_item_t r;
    int s;
    int pos;
    r = '0;
    r.status = ST_OK;
    s = -1;
    if (req.sem_key != 0)
      for (int i = 0; i < NSLOT; i++)
        if (s < 0 && tab_key[i] == req.sem_key) s = i;
    if (req.sem_key == 0) begin
      r.status = ST_NOT_FOUND;
    end else if (req.kind == KIND_OPEN) begin
      if (s < 0) begin
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && tab_key[i] == 0) s = i;
        if (s >= 0) begin
          clear_entry(s);
          tab_key[s] = req.sem_key;
          tab_count[s] = req.initial_count;
        end
      end
      if (s < 0) r.status = ST_TABLE_FULL;
      else if (tab_links[s] >= QDEPTH) r.status = ST_TOO_MANY_LINKS;
      else tab_links[s]++;
    end else if (s < 0) begin
      r.status = ST_NOT_FOUND;
    end else if (req.kind == KIND_CLOSE) begin
      if (tab_links[s] <= 1) clear_entry(s);
      else tab_links[s]--;
    end else if (req.kind == KIND_WAIT) begin
      if (tab_count[s] > 0) begin
        tab_count[s]--;
      end else if (tab_fill[s] >= QDEPTH) begin
        r.status = ST_QUEUE_FULL;
      end else begin
        pos = (tab_head[s] + tab_fill[s]) % QDEPTH;
        tab_waiters[s][pos] = req.caller_pid;
        tab_fill[s]++;
        r.caller_blocked = 1'b1;
      end
    end else begin
      if (tab_fill[s] > 0) begin
        r.wake_valid = 1'b1;
        r.wake_pid = tab_waiters[s][tab_head[s]];
        tab_head[s] = (tab_head[s] + 1) % QDEPTH;
        tab_fill[s]--;
      end else if (tab_count[s] != COUNT_MAX) begin
        tab_count[s]++;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  task automatic send_request(kind_t k, logic [31:0] key, logic [15:0] pid,
                              logic [15:0] init, bit gaps = 1'b1);
    in_item_t req;
    int g;
    req.kind = k;
    req.sem_key = key;
    req.caller_pid = pid;
    req.initial_count = init;
    g = gaps ? gap_len() : 0;
    repeat (g) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(semaphore_apply(req));
    in_valid <= 1'b0;
    // The block is busy with the transaction once it has taken it, so this edge costs nothing.
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off while long_hold is raised.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= $urandom_range(1);
    end else begin
      out_ready <= ($urandom_range(9) < 7) ? 1'b1 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status ||
            out_data.caller_blocked !== exp_r.caller_blocked ||
            out_data.wake_valid !== exp_r.wake_valid ||
            out_data.wake_pid !== exp_r.wake_pid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", exp_r, out_data);
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_request(KIND_OPEN, 32'h0, 16'h1, 16'h1);
    send_request(KIND_WAIT, 32'h0, 16'h1, 16'h0);
    send_request(KIND_POST, 32'h5, 16'h0, 16'h0);
    send_request(KIND_CLOSE, 32'h5, 16'h0, 16'h0);
    send_request(KIND_WAIT, 32'h5, 16'h0, 16'h0);
    send_request(KIND_OPEN, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    send_request(KIND_POST, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_request(KIND_WAIT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    send_request(KIND_OPEN, 32'h5, 16'h0, 16'h0);
    send_request(KIND_WAIT, 32'h5, 16'hFFFF, 16'h0);
    send_request(KIND_WAIT, 32'h5, 16'h0, 16'h0);
    send_request(KIND_POST, 32'h5, 16'h0, 16'h0);
    send_request(KIND_POST, 32'h5, 16'h0, 16'h0);
    send_request(KIND_POST, 32'h5, 16'h0, 16'h0);
    send_request(KIND_WAIT, 32'h5, 16'h0, 16'h0);
    send_request(KIND_CLOSE, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_request(KIND_CLOSE, 32'h5, 16'h0, 16'h0);
    send_request(KIND_CLOSE, 32'h5, 16'h0, 16'h0);
  endtask

  // Fill the queue past its depth and drain it, exhaust the links, fill the table, then close every key.
  task automatic test_limits();
    send_request(KIND_OPEN, 32'h77, 16'h0, 16'h0);
    for (int i = 0; i < QDEPTH + 2; i++)
      send_request(KIND_WAIT, 32'h77, 16'(i * 4099), 16'h0, 1'b0);
    for (int i = 0; i < QDEPTH + 2; i++)
      send_request(KIND_POST, 32'h77, 16'h0, 16'h0, 1'b0);
    for (int i = 0; i < QDEPTH + 1; i++)
      send_request(KIND_OPEN, 32'h77, 16'h0, 16'h0, 1'b0);
    for (int i = 0; i < NSLOT + 1; i++)
      send_request(KIND_OPEN, 32'h1000 + i, 16'h0, 16'(i), 1'b0);
    for (int i = 0; i < QDEPTH + 1; i++)
      send_request(KIND_CLOSE, 32'h77, 16'h0, 16'h0, 1'b0);
    for (int i = 0; i < NSLOT; i++)
      send_request(KIND_CLOSE, 32'h1000 + i, 16'h0, 16'h0, 1'b0);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++)
      send_request(kind_t'($urandom_range(3)), key_pool[$urandom_range(5)],
                   16'($urandom), 16'($urandom_range(2)), 1'b0);
    long_hold = 1'b0;
  endtask

  task automatic test_random();
    logic [31:0] key;
    for (int i = 0; i < 2000; i++) begin
      if ($urandom_range(19) == 0) key = $urandom;
      else if ($urandom_range(49) == 0) key = '0;
      else key = key_pool[$urandom_range(5)];
      send_request(kind_t'($urandom_range(3)), key, 16'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2)));
    end
  endtask

  initial begin
    int wait_cycles;
    for (int s = 0; s < NSLOT; s++) clear_entry(s);
    for (int i = 0; i < 6; i++) key_pool[i] = (i == 5) ? 32'hFFFF_FFFF : $urandom | 32'h1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_limits();
    test_backpressure();
    test_random();
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
